// File: design/color_memory_lcd_frame_serializer_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the color memory LCD frame serializer
// Shared shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef COLOR_MEMORY_LCD_FRAME_SERIALIZER_MACROS_SVH
`define COLOR_MEMORY_LCD_FRAME_SERIALIZER_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds at the same edge.
`define CMLFS_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication: when ante holds, cons holds at the following edge.
`define CMLFS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/cmlfs_pkg.sv
// ----------------------------------------------------------------------------
// cmlfs_pkg
// Geometry constants, descriptor types and queue sizing for the serializer.
// ----------------------------------------------------------------------------
package cmlfs_pkg;

  // Panel geometry.
  localparam int LINE_PIXELS = 128;
  localparam int LINE_COUNT  = 128;

  // Bytes per line are clamped to 2..128, lines per frame to 1..254.
  localparam int PAIRS_PER_LINE = (LINE_PIXELS / 2 < 2)   ? 2   :
                                  (LINE_PIXELS / 2 > 128) ? 128 : LINE_PIXELS / 2;
  localparam int LINES_TOTAL    = (LINE_COUNT < 1)   ? 1   :
                                  (LINE_COUNT > 254) ? 254 : LINE_COUNT;

  localparam logic [7:0] PAIRS_LIM = 8'(PAIRS_PER_LINE);
  localparam logic [7:0] LINES_LIM = 8'(LINES_TOTAL);

  // Bit sequence of one request: 16 header bits, 6 pixel bits, 8 trailer
  // bits and 8 bits of next address (or frame trailer).
  localparam int HDR_BITS = 16;
  localparam int PIX_BITS = 6;
  localparam int SEQ_LEN  = 38;
  localparam int POS_W    = $clog2(SEQ_LEN);

  localparam logic [POS_W-1:0] POS_PIX_FIRST = POS_W'(HDR_BITS);
  localparam logic [POS_W-1:0] POS_PIX_LAST  = POS_W'(HDR_BITS + PIX_BITS - 1);
  localparam logic [POS_W-1:0] POS_SEQ_LAST  = POS_W'(SEQ_LEN - 1);

  // Queue between the classifier and the serializer.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified request.
  typedef struct packed {
    logic          hdr;   // first byte of a frame: command and first address
    logic          eol;   // last byte of a line: trailer and next address
    logic          fin;   // last byte of the frame
    logic [5:0]    pix;   // pixel bits in transmit order
    logic [7:0]    addr;  // next line address
  } seg_desc_t;

  typedef struct packed {
    logic      push;
    seg_desc_t desc;
  } q_push_t;

  typedef struct packed {
    logic      nonempty;
    seg_desc_t desc;
  } q_head_t;

endpackage

// File: design/cmlfs_in_if.sv
// ----------------------------------------------------------------------------
// cmlfs_in_if
// Byte input channel: valid/ready handshake carrying one pixel pair.
// ----------------------------------------------------------------------------
interface cmlfs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] pixel_pair;

  modport source (output valid, output pixel_pair, input ready);
  modport sink   (input valid, input pixel_pair, output ready);
endinterface

// File: design/cmlfs_out_if.sv
// ----------------------------------------------------------------------------
// cmlfs_out_if
// Serial bit output channel: valid/ready handshake carrying one bit and marks.
// ----------------------------------------------------------------------------
interface cmlfs_out_if;
  logic valid;
  logic ready;
  logic serial_bit;
  logic last;
  logic frame_end;

  modport source (output valid, output serial_bit, output last, output frame_end,
                  input ready);
  modport sink   (input valid, input serial_bit, input last, input frame_end,
                  output ready);
endinterface

// File: design/color_memory_lcd_frame_serializer.sv
// ----------------------------------------------------------------------------
// color_memory_lcd_frame_serializer
// Turns frame-buffer bytes into the serial bit stream of a frame write.
// ----------------------------------------------------------------------------
//
//   Channel   Direction   Payload                           Request
//   in_ch     input       pixel_pair[7:0]                   one frame-buffer byte
//   out_ch    output      serial_bit, last, frame_end       one serial data bit
//
// The serializer sends one bit per clock while the output is taken and
// requests are queued. Mid-line, a byte sends its six pixel bits; the first
// byte of a frame adds the command and first address, and a line's last
// byte adds the trailer and next address or frame trailer. A line holds
// at least two bytes, so no byte both opens a frame and closes a line.
// That one-bit-per-clock output register alone sets the throughput.
// Synchronous active-low reset clears the line and byte counters, the queue
// and the output valid flag, so the next byte starts a new frame.
// A stall on the output backs up into the two-entry queue; input ready falls
// only when the queue is full, so bytes are taken while earlier ones drain.
//
// The front part classifies each byte at acceptance: whether it opens a
// frame, whether it closes a line, whether it closes the frame, and which
// line address follows. The classified request waits in a short queue, and
// the back part walks its bit sequence, skipping the sections that the
// request does not need. Line counting thus runs ahead of the serial line.
// ----------------------------------------------------------------------------
module color_memory_lcd_frame_serializer (
  input  logic        clk,
  input  logic        rst_n,
  cmlfs_in_if.sink    in_ch,
  cmlfs_out_if.source out_ch
);
  import cmlfs_pkg::*;

  q_push_t q_push;
  q_head_t q_head;
  logic    q_full;
  logic    q_pop;

  // Classifier: owns the frame position and feeds the queue.
  cmlfs_front u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push)
  );

  // Decouples byte acceptance from bit output.
  cmlfs_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (q_push),
    .q_full (q_full),
    .q_pop  (q_pop),
    .q_head (q_head)
  );

  // Serializer with its registered output stage.
  cmlfs_back u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_head (q_head),
    .q_pop  (q_pop),
    .out_ch (out_ch)
  );

endmodule

// File: design/cmlfs_front.sv
// ----------------------------------------------------------------------------
// cmlfs_front
// Accepts bytes, tracks line and byte position, and emits one descriptor each.
// ----------------------------------------------------------------------------
module cmlfs_front (
  input  logic              clk,
  input  logic              rst_n,
  cmlfs_in_if.sink          in_ch,
  input  logic              q_full,
  output cmlfs_pkg::q_push_t q_push
);
  import cmlfs_pkg::*;

  logic [7:0] line_r, line_nxt;
  logic [6:0] pair_r, pair_nxt;
  logic       accept;
  logic       hdr;
  logic [7:0] line_cur;
  logic [6:0] pair_inc;
  logic       eol;
  logic       fin;

  assign in_ch.ready = !q_full;
  assign accept      = in_ch.valid && !q_full;

  always_comb begin
    hdr      = (line_r == 8'd0);
    line_cur = hdr ? 8'd1 : line_r;
    pair_inc = (hdr ? 7'd0 : pair_r) + 7'd1;
    // A wrap of the 7-bit position also closes the line.
    eol      = (pair_inc == 7'd0) || ({1'b0, pair_inc} >= PAIRS_LIM);
    fin      = eol && (line_cur >= LINES_LIM);

    line_nxt = line_r;
    pair_nxt = pair_r;
    if (accept) begin
      if (eol) begin
        pair_nxt = 7'd0;
        line_nxt = fin ? 8'd0 : line_cur + 8'd1;
      end else begin
        pair_nxt = pair_inc;
        line_nxt = line_cur;
      end
    end

    q_push.push      = accept;
    q_push.desc.hdr  = hdr;
    q_push.desc.eol  = eol;
    q_push.desc.fin  = fin;
    q_push.desc.pix  = {in_ch.pixel_pair[6:4], in_ch.pixel_pair[2:0]};
    q_push.desc.addr = line_cur + 8'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_r <= 8'd0;
      pair_r <= 7'd0;
    end else begin
      line_r <= line_nxt;
      pair_r <= pair_nxt;
    end
  end

endmodule

// File: design/cmlfs_queue.sv
// ----------------------------------------------------------------------------
// cmlfs_queue
// Short descriptor FIFO between the classifier and the serializer.
// ----------------------------------------------------------------------------
module cmlfs_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  cmlfs_pkg::q_push_t q_push,
  output logic               q_full,
  input  logic               q_pop,
  output cmlfs_pkg::q_head_t q_head
);
  import cmlfs_pkg::*;

  seg_desc_t           mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wptr_r, wptr_nxt;
  logic [QPTR_W-1:0]   rptr_r, rptr_nxt;
  logic [QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign q_full          = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign q_head.nonempty = (cnt_r != '0);
  assign q_head.desc     = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (q_push.push) begin
      wptr_nxt = (wptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr_r + 1'b1;
    end
    if (q_pop) begin
      rptr_nxt = (rptr_r == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr_r + 1'b1;
    end
    case ({q_push.push, q_pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_push.push) begin
      mem_r[wptr_r] <= q_push.desc;
    end
  end

endmodule

// File: design/cmlfs_back.sv
// ----------------------------------------------------------------------------
// cmlfs_back
// Serializer: walks each descriptor's bits, one per clock unless stalled.
// ----------------------------------------------------------------------------
module cmlfs_back (
  input  logic               clk,
  input  logic               rst_n,
  input  cmlfs_pkg::q_head_t q_head,
  output logic               q_pop,
  cmlfs_out_if.source        out_ch
);
  import cmlfs_pkg::*;

  seg_desc_t          cur_r, cur_nxt;
  logic               cur_v_r, cur_v_nxt;
  logic [POS_W-1:0]   pos_r, pos_nxt;
  logic               out_v_r, out_v_nxt;
  logic               out_bit_r, out_bit_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_fe_r, out_fe_nxt;

  logic [SEQ_LEN-1:0] seq;
  logic [POS_W-1:0]   end_pos;
  logic               fire;
  logic               at_end;
  logic               load;

  always_comb begin
    // Command 0x80 MSB-first, then address 1 LSB-first: one set bit each.
    seq        = '0;
    seq[0]     = 1'b1;
    seq[8]     = 1'b1;
    seq[21:16] = cur_r.pix;
    seq[37:30] = cur_r.fin ? 8'd0 : cur_r.addr;

    end_pos = cur_r.eol ? POS_SEQ_LAST : POS_PIX_LAST;
    at_end  = (pos_r == end_pos);
    fire    = cur_v_r && (!out_v_r || out_ch.ready);
    load    = q_head.nonempty && (!cur_v_r || (fire && at_end));
    q_pop   = load;

    out_v_nxt    = out_v_r;
    out_bit_nxt  = out_bit_r;
    out_last_nxt = out_last_r;
    out_fe_nxt   = out_fe_r;
    if (fire) begin
      out_v_nxt    = 1'b1;
      out_bit_nxt  = seq[pos_r];
      out_last_nxt = at_end;
      out_fe_nxt   = at_end && cur_r.fin;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end

    cur_nxt   = cur_r;
    cur_v_nxt = cur_v_r;
    pos_nxt   = pos_r;
    if (load) begin
      cur_nxt   = q_head.desc;
      cur_v_nxt = 1'b1;
      pos_nxt   = q_head.desc.hdr ? '0 : POS_PIX_FIRST;
    end else if (fire && at_end) begin
      cur_v_nxt = 1'b0;
    end else if (fire) begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  assign out_ch.valid      = out_v_r;
  assign out_ch.serial_bit = out_bit_r;
  assign out_ch.last       = out_last_r;
  assign out_ch.frame_end  = out_fe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_v_r <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      cur_v_r <= cur_v_nxt;
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    out_bit_r  <= out_bit_nxt;
    out_last_r <= out_last_nxt;
    out_fe_r   <= out_fe_nxt;
  end

endmodule

// File: design/cmlfs_checker.sv
// ----------------------------------------------------------------------------
// cmlfs_checker
// Port-level checks on the serializer, attached to the top level by bind.
// ----------------------------------------------------------------------------
`include "color_memory_lcd_frame_serializer_macros.svh"

module cmlfs_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic serial_bit,
  input logic last,
  input logic frame_end
);

  `CMLFS_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid, "output request dropped while stalled")
  `CMLFS_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && !out_ready, $stable({serial_bit, last, frame_end}), "stalled output payload changed")
  `CMLFS_ASSERT_NOW(a_fe_last, clk, rst_n, out_valid && frame_end, last, "frame end without last")
  `CMLFS_ASSERT_NOW(a_ready_after_reset, clk, rst_n, $past(!rst_n), in_ready, "input not ready after reset")

endmodule

bind color_memory_lcd_frame_serializer cmlfs_checker u_cmlfs_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .serial_bit (out_ch.serial_bit),
  .last       (out_ch.last),
  .frame_end  (out_ch.frame_end)
);

// File: dv/color_memory_lcd_frame_serializer_tb.sv
// ----------------------------------------------------------------------------
// color_memory_lcd_frame_serializer_tb
// Feeds frame-buffer bytes into the serializer and checks every serial bit,
// with its last and frame_end marks, against a bit-level predictor of the
// frame write (command, line addresses, pixel bits, trailers) or typed-in
// rows. The panel geometry comes from cmlfs_pkg and cannot change at run
// time; the random part runs across several line ends of the first frame.
// ----------------------------------------------------------------------------
module color_memory_lcd_frame_serializer_tb;
  import cmlfs_pkg::*;

  // One serial bit as it leaves the block.
  typedef struct packed {
    logic serial_bit;
    logic last;
    logic frame_end;
  } serial_beat_t;

  // A row of the directed table. A nonzero bit_count means that the bits
  // of this request are typed in, first bit sent at bit_count-1. A zero
  // bit_count leaves the expectation to the predictor.
  typedef struct packed {
    logic [7:0]  pixel_pair;
    logic [4:0]  bit_count;
    logic [21:0] bits;
  } directed_row_t;

  localparam logic [7:0] WRITE_CMD  = 8'h80;
  localparam logic [7:0] FIRST_LINE = 8'h01;
  localparam logic [7:0] ZERO_BYTE  = 8'h00;

  // Pixel bits of a byte go out in this order; bits 3 and 7 are dropped.
  localparam int PIXEL_BIT [6] = '{0, 1, 2, 4, 5, 6};

  localparam int MAX_BITS    = 22;
  localparam int DIR_ROWS    = 14;

  // Random bytes: together with the directed rows about 370 requests.
  localparam int RANDOM_ITEMS = 370 - DIR_ROWS;
  localparam int CALM_FIRST   = 200;
  localparam int CALM_LAST    = 330;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = (DIR_ROWS + RANDOM_ITEMS) * MAX_BITS * 6 + 1000;

  // The first request after reset carries the command and the first line
  // address ahead of its pixels. The rest of the typed rows are mid-line
  // bytes, six bits each, which shows the pixel bit order directly.
  localparam directed_row_t DIRECTED [DIR_ROWS] = '{
    '{8'hFF, 5'd22, 22'b1000_0000_1000_0000_111111},
    '{8'h00, 5'd6,  22'b000000},
    '{8'h77, 5'd6,  22'b111111},
    '{8'h88, 5'd6,  22'b000000},
    '{8'h01, 5'd6,  22'b100000},
    '{8'h02, 5'd6,  22'b010000},
    '{8'h04, 5'd6,  22'b001000},
    '{8'h10, 5'd6,  22'b000100},
    '{8'h20, 5'd6,  22'b000010},
    '{8'h40, 5'd6,  22'b000001},
    '{8'h55, 5'd0,  22'b0},
    '{8'hAA, 5'd0,  22'b0},
    '{8'h0F, 5'd0,  22'b0},
    '{8'hF0, 5'd0,  22'b0}
  };

  logic clk;
  logic rst_n;

  cmlfs_in_if  in_ch ();
  cmlfs_out_if out_ch ();

  color_memory_lcd_frame_serializer u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Predictor state: line being sent (0 while no frame is open) and the
  // byte position within that line.
  logic [7:0] line_num;
  logic [6:0] pair_pos;

  serial_beat_t step_bits [$];     // bits of the request being predicted
  serial_beat_t pending_bits [$];  // bits predicted but not yet seen

  // Typed-in expectation of the request now offered on the input. These
  // change only at the falling edge, together with the request itself.
  logic [4:0]  typed_count;
  logic [21:0] typed_bits;

  // While set, neither side inserts idle cycles.
  logic no_gaps;

  int mismatches;
  int cycle_count;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  task automatic add_serial_bit(input logic b);
    step_bits.push_back('{b, 1'b0, 1'b0});
  endtask

  // Line addresses and trailer bytes go out least significant bit first.
  task automatic add_byte_lsb_first(input logic [7:0] v);
    int k;
    for (k = 0; k < 8; k++) add_serial_bit(v[k]);
  endtask

  // Works out every serial bit that one accepted byte causes and advances
  // the line and byte counters the way the panel write sequence does.
  task automatic serialize_pixel_pair(input logic [7:0] pp);
    serial_beat_t tail;
    logic         frame_done;
    int           k;
    frame_done = 1'b0;
    step_bits.delete();

    // A byte that arrives with no frame open opens one: the write command
    // goes out most significant bit first, then line address 1.
    if (line_num == 8'd0) begin
      for (k = 7; k >= 0; k--) add_serial_bit(WRITE_CMD[k]);
      add_byte_lsb_first(FIRST_LINE);
      line_num = 8'd1;
      pair_pos = '0;
    end

    for (k = 0; k < 6; k++) add_serial_bit(pp[PIXEL_BIT[k]]);

    // The byte counter is seven bits wide and closes the line on a wrap
    // as well as on reaching the line length.
    pair_pos = pair_pos + 7'd1;
    if (pair_pos == 7'd0 || int'(pair_pos) >= PAIRS_PER_LINE) begin
      pair_pos = '0;
      add_byte_lsb_first(ZERO_BYTE);
      if (int'(line_num) < LINES_TOTAL) begin
        line_num = line_num + 8'd1;
        add_byte_lsb_first(line_num);
      end else begin
        // Last line of the frame: a second zero byte, and the next byte
        // will start a fresh frame.
        add_byte_lsb_first(ZERO_BYTE);
        line_num   = 8'd0;
        frame_done = 1'b1;
      end
    end

    tail = step_bits.pop_back();
    tail.last      = 1'b1;
    tail.frame_end = frame_done;
    step_bits.push_back(tail);
  endtask

  // ---------------------------------------------------------------------------
  // Monitor and checker
  // ---------------------------------------------------------------------------

  task automatic compare_field(input string name, input logic want, input logic seen);
    if (seen !== want) begin
      $display("%0t: %s mismatch: expected %0b, actual %0b", $time, name, want, seen);
      mismatches++;
    end
  endtask

  // Both channels are sampled at the rising edge, before the block's own
  // registers update. Output is checked before the input of the same edge
  // is predicted, since a bit can never come out in the cycle its byte is
  // taken.
  always @(posedge clk) begin
    serial_beat_t want;
    int           i;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (pending_bits.size() == 0) begin
          $display("%0t: unexpected serial bit: expected none, actual bit %0b last %0b end %0b",
                   $time, out_ch.serial_bit, out_ch.last, out_ch.frame_end);
          mismatches++;
        end else begin
          want = pending_bits.pop_front();
          compare_field("serial_bit", want.serial_bit, out_ch.serial_bit);
          compare_field("last", want.last, out_ch.last);
          compare_field("frame_end", want.frame_end, out_ch.frame_end);
        end
      end

      if (in_ch.valid && in_ch.ready) begin
        // The predictor always runs so that its counters stay in step; a
        // typed-in row replaces only the bits that are expected.
        serialize_pixel_pair(in_ch.pixel_pair);
        if (typed_count != 5'd0) begin
          for (i = 0; i < int'(typed_count); i++) begin
            pending_bits.push_back('{typed_bits[int'(typed_count) - 1 - i],
                                     i == int'(typed_count) - 1, 1'b0});
          end
        end else begin
          foreach (step_bits[i]) pending_bits.push_back(step_bits[i]);
        end
      end
    end
  end

  // Hard stop if the block hangs or the stream stalls for good.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: ready drops about six percent of the time, never during
  // the calm stretch.
  // ---------------------------------------------------------------------------
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= no_gaps || ($urandom_range(99) >= 6);
    end
  end

  // ---------------------------------------------------------------------------
  // Sender
  // ---------------------------------------------------------------------------

  // Offers one request at the falling edge, with random idle cycles ahead
  // of it, and holds it until the block takes it.
  task automatic send_pixel_pair(input logic [7:0] pp, input logic [4:0] n,
                                 input logic [21:0] bits);
    while (!no_gaps && $urandom_range(99) < 6) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid      <= 1'b1;
    in_ch.pixel_pair <= pp;
    typed_count      <= n;
    typed_bits       <= bits;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // Holds the input idle until every predicted bit has come out. The
  // first wait keeps valid from being lowered and raised in the same step.
  task automatic wait_for_drain();
    in_ch.valid <= 1'b0;
    @(negedge clk);
    while (pending_bits.size() != 0) @(negedge clk);
  endtask

  // Random byte: mostly uniform, with the all-pixels-off, all-pixels-on and
  // ignored-bits-only patterns mixed in.
  function automatic logic [7:0] random_pixel_pair();
    case ($urandom_range(15))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'h77;
      3:       return 8'h88;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  initial begin
    int j;
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.pixel_pair = 8'h00;
    typed_count      = 5'd0;
    typed_bits       = '0;
    no_gaps          = 1'b0;
    line_num         = 8'd0;
    pair_pos         = '0;
    mismatches       = 0;
    cycle_count      = 0;

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: the frame opening after reset, every pixel bit alone,
    // the ignored bits, and a few mixed patterns.
    for (j = 0; j < DIR_ROWS; j++) begin
      send_pixel_pair(DIRECTED[j].pixel_pair, DIRECTED[j].bit_count, DIRECTED[j].bits);
    end

    // Let the serial line run dry once mid-line, so the next request finds
    // the block idle with a frame still open.
    wait_for_drain();

    // Random part. It crosses several line ends, each with its trailer and
    // the next line address.
    for (j = 0; j < RANDOM_ITEMS; j++) begin
      no_gaps = (j >= CALM_FIRST && j < CALM_LAST);
      send_pixel_pair(random_pixel_pair(), 5'd0, '0);
    end
    no_gaps = 1'b0;

    wait_for_drain();
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (pending_bits.size() != 0) begin
      $display("%0t: %0d expected serial bits never arrived", $time, pending_bits.size());
    end
    if (mismatches == 0 && pending_bits.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
